// ===== design/olist_pkg.sv =====
// Shared opcode and status codes of the ordered list.
`timescale 1ns / 1ps
`default_nettype none
package olist_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

endpackage : olist_pkg
`default_nettype wire

// ===== design/ordered_list_insert_delete_search.sv =====
// Bounded ordered list in one memory: insert at front, delete first match, search.
//
//   channel   ports                                   handshake
//   request   req_opcode, req_value                   start and not busy
//   response  rsp_status, rsp_position, rsp_count     rsp_valid, one cycle
//
// An insert keeps busy high while the single memory read port moves the n
// held entries one a cycle toward the back. A search or a delete keeps busy
// high while it scans from the front to its first match (or to the end); a
// delete also walks the tail to close the gap. Full, empty and no-op beats,
// and an insert into an empty list, are answered with busy never rising.
// The response is valid in the first cycle with busy low after the beat is
// taken, the cycle right after the accepting edge when busy never rises, and
// cannot be held off.
// Reset empties the list at once; the memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_insert_delete_search
   import olist_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_position,
   output logic [4:0]       rsp_count
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_INS_DRAIN,
      S_INS_FRONT,
      S_SCAN,
      S_SHIFT
   } state_type;

   state_type        state_ff;
   logic [CW-1:0]    used_ff;
   logic [CW-1:0]    rd_idx_ff;
   logic             pend_valid_ff;
   logic [AW-1:0]    pend_addr_ff;
   logic [31:0]      val_ff;
   logic             is_search_ff;
   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic [CW-1:0]    rsp_position_ff;

   logic [31:0]      mem [MAX_ENTRIES];
   logic [31:0]      rd_data_ff;

   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [31:0]      wr_data;
   logic             fwd_issue;
   logic             hit;
   logic             last_pend;
   logic [CW+4:0]    used_ext;
   logic [CW+4:0]    pos_ext;

   assign rd_addr   = rd_idx_ff[AW-1:0];
   assign fwd_issue = (rd_idx_ff < used_ff);
   assign hit       = pend_valid_ff && (rd_data_ff == val_ff);
   assign last_pend = (CW'(pend_addr_ff) == (used_ff - CW'(1)));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pend_addr_ff;
      wr_data = rd_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            wr_en   = start && (opcode_type'(req_opcode) == OP_INSERT) && (used_ff == '0);
            wr_addr = '0;
            wr_data = req_value;
         end
         S_INS, S_INS_DRAIN: begin
            wr_en   = pend_valid_ff;
            wr_addr = pend_addr_ff + AW'(1);
         end
         S_INS_FRONT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = val_ff;
         end
         S_SCAN: begin
            wr_en = 1'b0;
         end
         S_SHIFT: begin
            wr_en   = pend_valid_ff;
            wr_addr = pend_addr_ff - AW'(1);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               pend_valid_ff <= 1'b0;
               if (start) begin
                  val_ff          <= req_value;
                  rsp_status_ff   <= ST_OK;
                  rsp_position_ff <= '0;
                  unique case (opcode_type'(req_opcode))
                     OP_INSERT: begin
                        if (used_ff == CW'(MAX_ENTRIES)) begin
                           rsp_status_ff <= ST_FULL;
                           rsp_valid_ff  <= 1'b1;
                        end else if (used_ff == '0) begin
                           used_ff      <= used_ff + CW'(1);
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           rd_idx_ff <= used_ff - CW'(1);
                           state_ff  <= S_INS;
                        end
                     end
                     OP_DELETE, OP_SEARCH: begin
                        is_search_ff <= (opcode_type'(req_opcode) == OP_SEARCH);
                        if (used_ff == '0) begin
                           rsp_status_ff <= ST_EMPTY;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           rd_idx_ff <= '0;
                           state_ff  <= S_SCAN;
                        end
                     end
                     OP_NOP: begin
                        rsp_valid_ff <= 1'b1;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_INS: begin
               pend_valid_ff <= 1'b1;
               pend_addr_ff  <= rd_addr;
               rd_idx_ff     <= rd_idx_ff - CW'(1);
               if (rd_idx_ff == '0) begin
                  state_ff <= S_INS_DRAIN;
               end
            end
            S_INS_DRAIN: begin
               pend_valid_ff <= 1'b0;
               state_ff      <= S_INS_FRONT;
            end
            S_INS_FRONT: begin
               used_ff      <= used_ff + CW'(1);
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_SCAN: begin
               pend_valid_ff <= fwd_issue;
               pend_addr_ff  <= rd_addr;
               rd_idx_ff     <= rd_idx_ff + CW'(fwd_issue);
               if (hit) begin
                  if (is_search_ff) begin
                     rsp_position_ff <= CW'(pend_addr_ff) + CW'(1);
                     rsp_valid_ff    <= 1'b1;
                     state_ff        <= S_IDLE;
                  end else begin
                     state_ff <= S_SHIFT;
                  end
               end else if (pend_valid_ff && last_pend) begin
                  rsp_status_ff <= ST_NOTFOUND;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_SHIFT: begin
               pend_valid_ff <= fwd_issue;
               pend_addr_ff  <= rd_addr;
               rd_idx_ff     <= rd_idx_ff + CW'(fwd_issue);
               if (!pend_valid_ff && !fwd_issue) begin
                  used_ff      <= used_ff - CW'(1);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign used_ext = {5'd0, used_ff};
   assign pos_ext  = {5'd0, rsp_position_ff};

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = pos_ext[4:0];
   assign rsp_count    = used_ext[4:0];

endmodule : ordered_list_insert_delete_search
`default_nettype wire

// ===== test/ordered_list_insert_delete_search_test.sv =====
// Self-checking testbench that compares every list response with a predictor.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_insert_delete_search_test
   import olist_pkg::*;
();

   localparam int LIST_DEPTH = 16;
   localparam int RANDOM_BEATS = 920;

   typedef struct packed {
      status_type status;
      logic [4:0] position;
      logic [4:0] count;
   } list_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = OP_NOP;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_position;
   logic [4:0]  rsp_count;

   logic [31:0]     list_slots [LIST_DEPTH];
   int unsigned     list_held = 0;
   list_answer_type pending_answers [$];
   int unsigned     mismatch_count = 0;

   ordered_list_insert_delete_search #(
      .MAX_ENTRIES(LIST_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_position(rsp_position),
      .rsp_count(rsp_count)
   );

   always #10 clock = ~clock;

   function automatic list_answer_type predict_list_op(opcode_type op, logic [31:0] v);
      list_answer_type ans;
      int unsigned hit;
      ans.status = ST_OK;
      ans.position = '0;
      case (op)
         OP_INSERT: begin
            if (list_held >= LIST_DEPTH) begin
               ans.status = ST_FULL;
            end else begin
               for (int i = list_held; i > 0; i--) list_slots[i] = list_slots[i - 1];
               list_slots[0] = v;
               list_held++;
            end
         end
         OP_DELETE, OP_SEARCH: begin
            if (list_held == 0) begin
               ans.status = ST_EMPTY;
            end else begin
               hit = list_held;
               for (int i = 0; i < list_held; i++) begin
                  if (hit == list_held && list_slots[i] == v) hit = i;
               end
               if (hit == list_held) begin
                  ans.status = ST_NOTFOUND;
               end else if (op == OP_SEARCH) begin
                  ans.position = 5'(hit + 1);
               end else begin
                  for (int i = hit; i + 1 < list_held; i++) list_slots[i] = list_slots[i + 1];
                  list_held--;
               end
            end
         end
         default: ;
      endcase
      ans.count = 5'(list_held);
      return ans;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            if (list_held != 0) return list_slots[$urandom_range(0, list_held - 1)];
            return $urandom;
         end
         4, 5: return 32'($urandom_range(0, 7));
         6: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Start is left high after the beat is taken; the caller either sends again
   // in the same step or lowers it through a pause.
   task automatic send_beat(opcode_type op, logic [31:0] v);
      start <= 1'b1;
      req_opcode <= op;
      req_value <= v;
      do @(posedge clock); while (busy);
      pending_answers.push_back(predict_list_op(op, v));
   endtask

   task automatic pause_sender(int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_all_answered();
      start <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic test_empty_list();
      send_beat(OP_SEARCH, 32'd5);
      send_beat(OP_DELETE, 32'd5);
      send_beat(OP_NOP, 32'hFFFF_FFFF);
      send_beat(OP_DELETE, 32'h8000_0000);
   endtask

   task automatic test_extreme_values();
      send_beat(OP_INSERT, 32'h8000_0000);
      send_beat(OP_INSERT, 32'h7FFF_FFFF);
      send_beat(OP_INSERT, 32'h0000_0000);
      send_beat(OP_INSERT, 32'hFFFF_FFFF);
      send_beat(OP_SEARCH, 32'h8000_0000);
      send_beat(OP_SEARCH, 32'hFFFF_FFFF);
      send_beat(OP_SEARCH, 32'h1234_5678);
      send_beat(OP_DELETE, 32'h7FFF_FFFF);
      send_beat(OP_NOP, 32'h5555_5555);
      send_beat(OP_SEARCH, 32'h0000_0000);
   endtask

   task automatic test_duplicates();
      send_beat(OP_INSERT, 32'd5);
      send_beat(OP_INSERT, 32'd5);
      send_beat(OP_SEARCH, 32'd5);
      send_beat(OP_DELETE, 32'd5);
      send_beat(OP_DELETE, 32'd5);
      send_beat(OP_DELETE, 32'd5);
   endtask

   task automatic test_full_list();
      wait_all_answered();
      while (list_held < LIST_DEPTH) send_beat(OP_INSERT, $urandom);
      send_beat(OP_INSERT, 32'hA5A5_A5A5);
      send_beat(OP_SEARCH, list_slots[LIST_DEPTH - 1]);
      send_beat(OP_DELETE, list_slots[LIST_DEPTH - 1]);
      send_beat(OP_DELETE, list_slots[0]);
   endtask

   // Phases alternate between growing and shrinking the list so that both the
   // full and the empty ends are visited many times.
   task automatic test_random_mix();
      bit          filling;
      int unsigned phase_left;
      int unsigned burst_left;
      int unsigned roll;
      int unsigned gap;
      opcode_type  op;
      logic [31:0] v;
      filling = 1'b0;
      phase_left = 0;
      burst_left = 0;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (phase_left == 0) begin
            filling = !filling;
            phase_left = $urandom_range(30, 80);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            op = OP_NOP;
         end else if (roll < 30) begin
            op = OP_SEARCH;
         end else if (roll < (filling ? 85 : 45)) begin
            op = OP_INSERT;
         end else begin
            op = OP_DELETE;
         end
         if (op == OP_DELETE && list_held != 0 && $urandom_range(0, 1) == 1) begin
            v = list_slots[$urandom_range(0, list_held - 1)];
         end else begin
            v = pick_value();
         end
         if (n % 300 == 150) begin
            wait_all_answered();
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0) pause_sender(gap);
         end else begin
            burst_left--;
         end
         send_beat(op, v);
      end
   endtask

   always @(posedge clock) begin
      list_answer_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("unexpected beat: status %0d position %0d count %0d",
                        rsp_status, rsp_position, rsp_count);
            end
            mismatch_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status || rsp_position !== want.position ||
                rsp_count !== want.count) begin
               if (mismatch_count < 10) begin
                  $display("mismatch: expected status %0d position %0d count %0d, got %0d %0d %0d",
                           want.status, want.position, want.count,
                           rsp_status, rsp_position, rsp_count);
               end
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_extreme_values();
      test_duplicates();
      test_full_list();
      test_random_mix();
      wait_all_answered();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("ordered_list_insert_delete_search_test: PASS");
      end else begin
         $display("ordered_list_insert_delete_search_test: FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("ordered_list_insert_delete_search_test: FAIL");
      $finish;
   end

endmodule : ordered_list_insert_delete_search_test
`default_nettype wire

// ===== filelist.f =====
design/olist_pkg.sv
design/ordered_list_insert_delete_search.sv
test/ordered_list_insert_delete_search_test.sv
